[sv/wepr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package wepr_pkg;

    localparam int MAX_LEN    = 65536;
    localparam int NUM_COLORS = 65536;
    localparam int POS_W      = 16;
    localparam int COL_W      = 16;
    localparam int CNT_W      = 17;
    localparam int EDGE_W     = 17;
    localparam int SS_W       = 33;
    localparam int FR_W       = 32;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_BAD   = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [POS_W-1:0]   position;
        logic [COL_W-1:0]   color;
        logic [POS_W-1:0]   left;
        logic [POS_W-1:0]   right;
    } t_cmd;

    typedef struct packed {
        logic clearing;
        logic pop;
    } t_back_stat;

endpackage
`default_nettype wire

[sv/wepr_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module wepr_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic                       i_req_type,
    input  logic [wepr_pkg::POS_W-1:0] i_position,
    input  logic [wepr_pkg::COL_W-1:0] i_color,
    input  logic [wepr_pkg::POS_W-1:0] i_left,
    input  logic [wepr_pkg::POS_W-1:0] i_right,
    input  wepr_pkg::t_back_stat       i_stat,
    output logic                       o_busy,
    output logic                       o_cmd_valid,
    output wepr_pkg::t_cmd             o_cmd
);
    import wepr_pkg::*;

    t_cmd        r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    t_cmd        cmd_in;

    always_comb begin
        cmd_in.position = i_position;
        cmd_in.color    = i_color;
        cmd_in.left     = i_left;
        cmd_in.right    = i_right;
        if (!i_req_type) begin
            cmd_in.kind = KIND_LOAD;
        end else if (i_left > i_right
                     || {1'b0, i_right} >= EDGE_W'(MAX_LEN)) begin
            cmd_in.kind = KIND_BAD;
        end else begin
            cmd_in.kind = KIND_QUERY;
        end
    end

    assign o_busy      = i_stat.clearing | (r_cnt == 2'd2);
    assign push        = i_start & ~o_busy;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_stat.pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_stat.pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.pop |-> r_cnt != 2'd0)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

[sv/wepr_frac.sv]
`timescale 1ns / 1ps
`default_nettype none
module wepr_frac (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wepr_pkg::FR_W-1:0] i_num,
    input  logic [wepr_pkg::FR_W-1:0] i_den,
    output logic                      o_done,
    output logic [wepr_pkg::FR_W-1:0] o_num,
    output logic [wepr_pkg::FR_W-1:0] o_den
);
    import wepr_pkg::*;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_GCD  = 4'b0010,
        F_DIVN = 4'b0100,
        F_DIVD = 4'b1000
    } t_fstate;

    t_fstate           r_state;
    logic [FR_W-1:0]   r_a, r_b, r_g, r_n, r_d, r_quo, r_rem;
    logic [4:0]        r_k, r_cnt;
    logic              r_done;
    logic [FR_W-1:0]   r_qn, r_qd;
    logic [FR_W:0]     rem_sh;
    logic              ge;
    logic [FR_W-1:0]   quo_nx, rem_nx;

    // one restoring step of quotient / g
    always_comb begin
        rem_sh = {r_rem, r_quo[FR_W-1]};
        ge     = rem_sh >= {1'b0, r_g};
        rem_nx = ge ? FR_W'(rem_sh - {1'b0, r_g}) : rem_sh[FR_W-1:0];
        quo_nx = {r_quo[FR_W-2:0], ge};
    end

    assign o_done = r_done;
    assign o_num  = r_qn;
    assign o_den  = r_qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                F_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_num;
                        r_b     <= i_den;
                        r_n     <= i_num;
                        r_d     <= i_den;
                        r_k     <= '0;
                        r_state <= F_GCD;
                    end
                end
                F_GCD: begin
                    // binary gcd, one step per cycle
                    if (r_b == '0 || r_a == '0) begin
                        r_g     <= (r_b == '0) ? (r_a << r_k) : (r_b << r_k);
                        r_quo   <= r_n;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= F_DIVN;
                    end else if (!r_a[0] && !r_b[0]) begin
                        r_a <= r_a >> 1;
                        r_b <= r_b >> 1;
                        r_k <= r_k + 5'd1;
                    end else if (!r_a[0]) begin
                        r_a <= r_a >> 1;
                    end else if (!r_b[0]) begin
                        r_b <= r_b >> 1;
                    end else if (r_a >= r_b) begin
                        r_a <= (r_a - r_b) >> 1;
                    end else begin
                        r_b <= (r_b - r_a) >> 1;
                    end
                end
                F_DIVN: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_qn    <= quo_nx;
                        r_quo   <= r_d;
                        r_rem   <= '0;
                        r_state <= F_DIVD;
                    end else begin
                        r_quo <= quo_nx;
                        r_rem <= rem_nx;
                    end
                end
                F_DIVD: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_qd    <= quo_nx;
                        r_done  <= 1'b1;
                        r_state <= F_IDLE;
                    end else begin
                        r_quo <= quo_nx;
                        r_rem <= rem_nx;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[sv/wepr_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module wepr_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cmd_valid,
    input  wepr_pkg::t_cmd            i_cmd,
    output wepr_pkg::t_back_stat      o_stat,
    output logic                      o_valid,
    output logic [wepr_pkg::FR_W-1:0] o_numerator,
    output logic [wepr_pkg::FR_W-1:0] o_denominator,
    output logic                      o_status
);
    import wepr_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_PLAN  = 8'b0000_0100,
        S_RDCOL = 8'b0000_1000,
        S_RDCNT = 8'b0001_0000,
        S_UPD   = 8'b0010_0000,
        S_MUL   = 8'b0100_0000,
        S_FRAC  = 8'b1000_0000
    } t_state;

    logic [COL_W-1:0]  color_mem [MAX_LEN];
    logic [CNT_W-1:0]  count_mem [NUM_COLORS];

    t_state            r_state;
    t_cmd              r_cmd;
    logic [EDGE_W-1:0] r_ws, r_we;
    logic [SS_W-1:0]   r_ss;
    logic [POS_W-1:0]  r_pos;
    logic              r_grow;
    logic [COL_W-1:0]  r_clr;
    logic [COL_W-1:0]  color_q;
    logic [CNT_W-1:0]  count_q;
    logic [EDGE_W-1:0] r_len;
    logic              r_out_valid, r_out_status;
    logic [FR_W-1:0]   r_out_num, r_out_den;

    logic [EDGE_W-1:0] left_x, tgt, len;
    logic              col_we, cnt_we;
    logic [COL_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic              frac_start, frac_done;
    logic [FR_W-1:0]   frac_num_in, frac_den_in, frac_num, frac_den;
    logic [2*EDGE_W-1:0] prod;

    assign left_x = {1'b0, r_cmd.left};
    assign tgt    = {1'b0, r_cmd.right} + EDGE_W'(1);
    assign len    = tgt - left_x;

    assign col_we = (r_state == S_PLAN) && (r_cmd.kind == KIND_LOAD) && !(r_ws < r_we);

    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = color_q;
        cnt_wdata = '0;
        if (r_state == S_CLEAR) begin
            cnt_we    = 1'b1;
            cnt_waddr = r_clr;
        end else if (r_state == S_UPD) begin
            if (r_grow) begin
                cnt_we    = 1'b1;
                cnt_wdata = count_q + CNT_W'(1);
            end else if (count_q != '0) begin
                cnt_we    = 1'b1;
                cnt_wdata = count_q - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            color_mem[r_cmd.position] <= r_cmd.color;
        end
        color_q <= color_mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        count_q <= count_mem[color_q];
    end

    assign prod        = r_len * (r_len - EDGE_W'(1));
    assign frac_start  = (r_state == S_MUL);
    assign frac_num_in = FR_W'(r_ss - {{(SS_W-EDGE_W){1'b0}}, r_len});
    assign frac_den_in = prod[FR_W-1:0];

    wepr_frac u_frac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (frac_start),
        .i_num   (frac_num_in),
        .i_den   (frac_den_in),
        .o_done  (frac_done),
        .o_num   (frac_num),
        .o_den   (frac_den)
    );

    assign o_stat.clearing = (r_state == S_CLEAR);
    assign o_stat.pop      = (r_state == S_IDLE) && i_cmd_valid;
    assign o_valid         = r_out_valid;
    assign o_numerator     = r_out_num;
    assign o_denominator   = r_out_den;
    assign o_status        = r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_ws        <= '0;
            r_we        <= '0;
            r_ss        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + COL_W'(1);
                    if (r_clr == COL_W'(NUM_COLORS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cmd   <= i_cmd;
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    unique case (r_cmd.kind)
                        KIND_LOAD: begin
                            if (r_ws < r_we) begin
                                r_pos   <= r_ws[POS_W-1:0];
                                r_grow  <= 1'b0;
                                r_ws    <= r_ws + EDGE_W'(1);
                                r_state <= S_RDCOL;
                            end else begin
                                r_ws    <= '0;
                                r_we    <= '0;
                                r_ss    <= '0;
                                r_state <= S_IDLE;
                            end
                        end
                        KIND_BAD: begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= 1'b1;
                            r_out_num    <= '0;
                            r_out_den    <= '0;
                            r_state      <= S_IDLE;
                        end
                        KIND_QUERY: begin
                            // grow both edges first, then shrink
                            if (r_ws > left_x) begin
                                r_pos   <= POS_W'(r_ws - EDGE_W'(1));
                                r_grow  <= 1'b1;
                                r_ws    <= r_ws - EDGE_W'(1);
                                r_state <= S_RDCOL;
                            end else if (r_we < tgt) begin
                                r_pos   <= r_we[POS_W-1:0];
                                r_grow  <= 1'b1;
                                r_we    <= r_we + EDGE_W'(1);
                                r_state <= S_RDCOL;
                            end else if (r_ws < left_x) begin
                                r_pos   <= r_ws[POS_W-1:0];
                                r_grow  <= 1'b0;
                                r_ws    <= r_ws + EDGE_W'(1);
                                r_state <= S_RDCOL;
                            end else if (r_we > tgt) begin
                                r_pos   <= POS_W'(r_we - EDGE_W'(1));
                                r_grow  <= 1'b0;
                                r_we    <= r_we - EDGE_W'(1);
                                r_state <= S_RDCOL;
                            end else if (len == EDGE_W'(1)) begin
                                r_out_valid  <= 1'b1;
                                r_out_status <= 1'b0;
                                r_out_num    <= '0;
                                r_out_den    <= FR_W'(1);
                                r_state      <= S_IDLE;
                            end else begin
                                r_len   <= len;
                                r_state <= S_MUL;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_RDCOL: r_state <= S_RDCNT;
                S_RDCNT: r_state <= S_UPD;
                S_UPD: begin
                    if (r_grow) begin
                        r_ss <= r_ss + SS_W'({count_q, 1'b1});
                    end else if (count_q != '0) begin
                        r_ss <= r_ss - SS_W'({count_q - CNT_W'(1), 1'b1});
                    end
                    r_state <= S_PLAN;
                end
                S_MUL: r_state <= S_FRAC;
                S_FRAC: begin
                    if (frac_done) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= 1'b0;
                        r_out_num    <= frac_num;
                        r_out_den    <= frac_den;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ws <= r_we)
        else $error("window start passed window end");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status |-> r_out_num == '0 && r_out_den == '0)
        else $error("bad range result carries a fraction");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_status |-> r_out_den != '0)
        else $error("zero denominator on a valid answer");

endmodule
`default_nettype wire

[sv/window_equal_pair_ratio.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   | handshake                 | payload
// ----------+---------------------------+--------------------------------------------
// request   | start in, busy out        | i_req_type i_position i_color i_left i_right
// result    | o_valid strobe, one cycle | o_numerator o_denominator o_status
//
// after reset the color count memory is cleared, one entry a cycle: busy stays high
// until all 65536 entries are clear. a two-entry queue takes requests while the
// window engine works. each window edge step passes through the states position read,
// count read, update and plan; a load walks the whole current window, a query walks
// only the edge distance. the fraction unit runs a binary gcd, then two divides;
// results cannot be stalled. busy rises while the count memory is cleared or the queue is full.
module window_equal_pair_ratio (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_req_type,
    input  logic [wepr_pkg::POS_W-1:0] i_position,
    input  logic [wepr_pkg::COL_W-1:0] i_color,
    input  logic [wepr_pkg::POS_W-1:0] i_left,
    input  logic [wepr_pkg::POS_W-1:0] i_right,
    output logic                       o_valid,
    output logic [wepr_pkg::FR_W-1:0]  o_numerator,
    output logic [wepr_pkg::FR_W-1:0]  o_denominator,
    output logic                       o_status
);
    import wepr_pkg::*;

    t_back_stat stat;
    t_cmd       cmd;
    logic       cmd_valid;

    wepr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req_type  (i_req_type),
        .i_position  (i_position),
        .i_color     (i_color),
        .i_left      (i_left),
        .i_right     (i_right),
        .i_stat      (stat),
        .o_busy      (busy),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    wepr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_valid       (o_valid),
        .o_numerator   (o_numerator),
        .o_denominator (o_denominator),
        .o_status      (o_status)
    );

endmodule
`default_nettype wire
